// File: rtl/core/base64_stream_codec_core_macros.svh
// Assertion macros for the codec RTL.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define B64C_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("codec assertion failed");

// Next-cycle implication, checked out of reset.
`define B64C_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("codec assertion failed");

`else

`define B64C_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define B64C_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/b64c_pkg.sv
package b64c_pkg;

    localparam int unsigned MaxRes = 4;
    localparam int unsigned ResCntW = 3;

    localparam logic [7:0] AsciiPad   = 8'h3D;
    localparam logic [7:0] AsciiUpA   = 8'h41;
    localparam logic [7:0] AsciiUpZ   = 8'h5A;
    localparam logic [7:0] AsciiLowA  = 8'h61;
    localparam logic [7:0] AsciiLowZ  = 8'h7A;
    localparam logic [7:0] AsciiZero  = 8'h30;
    localparam logic [7:0] AsciiNine  = 8'h39;
    localparam logic [7:0] AsciiPlus  = 8'h2B;
    localparam logic [7:0] AsciiSlash = 8'h2F;
    localparam logic [7:0] AsciiMinus = 8'h2D;
    localparam logic [7:0] AsciiUnder = 8'h5F;

    // Configuration register indexes (paddr bit 2).
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_ALPHABET  = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic ALPH_STD   = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CHAR = 2'd1,
        STATUS_LEN  = 2'd2
    } b64c_status_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         valid;
        logic         last;
        b64c_status_t status;
    } b64c_res_t;

    typedef struct packed {
        logic [5:0] leftover_bits;
        logic [2:0] leftover_count;
        logic [1:0] phase;
        logic       seen_four;
        logic [1:0] pad_seen;
        logic       char_error;
    } b64c_state_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } b64c_val_t;

    function automatic logic [7:0] sym_of(input logic [5:0] v, input logic alph);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = AsciiUpA + {2'b00, v};
        end else if (v < 6'd52) begin
            c = AsciiLowA + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = AsciiZero + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = alph ? AsciiMinus : AsciiPlus;
        end else begin
            c = alph ? AsciiUnder : AsciiSlash;
        end
        return c;
    endfunction

    function automatic b64c_val_t val_of(input logic [7:0] c, input logic alph);
        b64c_val_t r;
        r = '0;
        if (c >= AsciiUpA && c <= AsciiUpZ) begin
            r.ok = 1'b1;
            r.value = 6'(c - AsciiUpA);
        end else if (c >= AsciiLowA && c <= AsciiLowZ) begin
            r.ok = 1'b1;
            r.value = 6'(c - AsciiLowA + 8'd26);
        end else if (c >= AsciiZero && c <= AsciiNine) begin
            r.ok = 1'b1;
            r.value = 6'(c - AsciiZero + 8'd52);
        end else if (c == (alph ? AsciiMinus : AsciiPlus)) begin
            r.ok = 1'b1;
            r.value = 6'd62;
        end else if (c == (alph ? AsciiUnder : AsciiSlash)) begin
            r.ok = 1'b1;
            r.value = 6'd63;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/b64c_step.sv
module b64c_step
    import b64c_pkg::*;
(
    input  logic                  direction,
    input  logic                  alphabet,
    input  b64c_state_t           state_cur,
    input  logic [7:0]            data_in,
    input  logic                  last_in,
    output b64c_state_t           state_next,
    output b64c_res_t [MaxRes-1:0] res,
    output logic [ResCntW-1:0]    res_count
);

    logic [13:0] enc_bits;
    logic [3:0]  enc_cnt;
    logic [11:0] dec_bits;
    logic [3:0]  dec_cnt;
    logic [1:0]  phase;
    logic [ResCntW-1:0] n;
    b64c_val_t   dv;
    logic        len_bad;

    always_comb begin
        state_next = state_cur;
        res        = '0;
        n          = '0;
        phase      = state_cur.phase;
        enc_bits   = {state_cur.leftover_bits, data_in};
        enc_cnt    = {1'b0, state_cur.leftover_count} + 4'd8;
        dv         = val_of(data_in, alphabet);
        dec_bits   = {state_cur.leftover_bits, dv.value};
        dec_cnt    = {1'b0, state_cur.leftover_count} + 4'd6;
        len_bad    = 1'b0;

        if (direction == DIR_ENCODE) begin
            // Emit every full 6-bit group; a byte yields one or two.
            for (int k = 0; k < 2; k++) begin
                if (enc_cnt >= 4'd6) begin
                    enc_cnt = enc_cnt - 4'd6;
                    res[n[1:0]].data  = sym_of(6'(enc_bits >> enc_cnt), alphabet);
                    res[n[1:0]].valid = 1'b1;
                    n     = n + 1'b1;
                    phase = phase + 2'd1;
                end
            end
            state_next.leftover_bits  = 6'(enc_bits & ((14'd1 << enc_cnt) - 14'd1));
            state_next.leftover_count = enc_cnt[2:0];
            state_next.phase          = phase;
            if (last_in) begin
                if (state_next.leftover_count != 3'd0) begin
                    res[n[1:0]].data  = sym_of(6'(state_next.leftover_bits
                                        << (3'd6 - state_next.leftover_count)), alphabet);
                    res[n[1:0]].valid = 1'b1;
                    n     = n + 1'b1;
                    phase = phase + 2'd1;
                end
                for (int k = 0; k < 3; k++) begin
                    if (alphabet == ALPH_STD && phase != 2'd0 && n < ResCntW'(MaxRes)) begin
                        res[n[1:0]].data  = AsciiPad;
                        res[n[1:0]].valid = 1'b1;
                        n     = n + 1'b1;
                        phase = phase + 2'd1;
                    end
                end
                if (n != '0) begin
                    res[2'(n - 1'b1)].last = 1'b1;
                end
                state_next = '0;
            end
        end else begin
            phase = phase + 2'd1;
            state_next.phase = phase;
            if (phase == 2'd0) begin
                state_next.seen_four = 1'b1;
            end
            if (data_in == AsciiPad) begin
                if (state_cur.pad_seen >= 2'd2) begin
                    state_next.char_error = 1'b1;
                end else begin
                    state_next.pad_seen = state_cur.pad_seen + 2'd1;
                end
            end else begin
                if (state_cur.pad_seen != 2'd0 || !dv.ok) begin
                    state_next.char_error = 1'b1;
                end
                if (!state_next.char_error) begin
                    if (dec_cnt >= 4'd8) begin
                        dec_cnt = dec_cnt - 4'd8;
                        res[0].data  = 8'(dec_bits >> dec_cnt);
                        res[0].valid = 1'b1;
                        n = ResCntW'(1);
                    end
                    state_next.leftover_bits  = 6'(dec_bits & ((12'd1 << dec_cnt) - 12'd1));
                    state_next.leftover_count = dec_cnt[2:0];
                end
            end
            if (last_in) begin
                if (alphabet == ALPH_STD) begin
                    len_bad = (state_next.phase != 2'd0) || !state_next.seen_four;
                end else begin
                    len_bad = (state_next.phase == 2'd1);
                end
                if (state_next.pad_seen != 2'd0 && state_next.phase != 2'd0) begin
                    state_next.char_error = 1'b1;
                end
                // A last character that leaves no byte still closes the message.
                n = ResCntW'(1);
                res[0].last = 1'b1;
                if (len_bad) begin
                    res[0].status = STATUS_LEN;
                end else if (state_next.char_error) begin
                    res[0].status = STATUS_CHAR;
                end else begin
                    res[0].status = STATUS_OK;
                end
                state_next = '0;
            end
        end
        res_count = n;
    end

endmodule

// File: rtl/core/b64c_outbuf.sv
module b64c_outbuf
    import b64c_pkg::*;
`include "base64_stream_codec_core_macros.svh"
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  b64c_res_t [MaxRes-1:0] load_res,
    input  logic [ResCntW-1:0]     load_count,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output b64c_res_t              out_res
);

    b64c_res_t [MaxRes-1:0] slot_reg, slot_next;
    logic [ResCntW-1:0]     count_reg, count_next;
    logic                   drain;

    assign out_valid = (count_reg != '0);
    assign drain     = out_valid && out_ready;
    // A new set may enter once the last waiting result leaves this cycle.
    assign can_load  = (count_reg == '0) || (count_reg == ResCntW'(1) && out_ready);
    assign out_res   = slot_reg[0];

    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (load) begin
            slot_next  = load_res;
            count_next = load_count;
        end else if (drain) begin
            for (int i = 0; i < MaxRes - 1; i++) begin
                slot_next[i] = slot_reg[i+1];
            end
            slot_next[MaxRes-1] = '0;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    `B64C_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= ResCntW'(MaxRes))
    `B64C_ASSERT_NOW(a_load_when_free, aclk, aresetn, load,
        count_reg == '0 || (count_reg == ResCntW'(1) && out_ready))
    `B64C_ASSERT_NEXT(a_load_shows, aclk, aresetn, load && load_count != '0,
        out_valid && count_reg == $past(load_count))
    `B64C_ASSERT_NEXT(a_drain_step, aclk, aresetn, drain && !load,
        count_reg == $past(count_reg) - 1'b1)

endmodule

// File: rtl/core/base64_stream_codec_core.sv
// Results are registered: one is offered on m_tvalid in the cycle after its input transaction.
// Throughput: one input transaction per cycle while each item yields at most one
// result and m_tready is high; the single result port sets the rate, so an item
// with more results holds off the next input until all but its last have left.
// Reset: aresetn is synchronous, active low; it clears the configuration
// (encode, standard alphabet), the message state and the result buffer.
module base64_stream_codec_core
    import b64c_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic        s_tlast,   // last_in
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic        m_tlast,   // last_out
    output logic [2:0]  m_tuser,   // [0] data_valid, [2:1] status
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers. A write to either one also aborts any message
    // in progress, so the message state is cleared on every write.
    logic direction_reg, direction_next;
    logic alphabet_reg, alphabet_next;
    logic cfg_write;

    // Message state carried from one input transaction to the next.
    b64c_state_t state_reg, state_next;
    b64c_state_t step_state;

    b64c_res_t [MaxRes-1:0] step_res;
    logic [ResCntW-1:0]     step_count;
    logic                   s_accept;
    logic                   buf_free;
    b64c_res_t              head_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        direction_next = direction_reg;
        alphabet_next  = alphabet_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_DIRECTION: direction_next = pwdata[0];
                REG_ALPHABET:  alphabet_next  = pwdata[0];
                default:       direction_next = direction_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DIRECTION: prdata = {31'd0, direction_reg};
            REG_ALPHABET:  prdata = {31'd0, alphabet_reg};
            default:       prdata = '0;
        endcase
    end

    // The input side is ready whenever the result buffer can take a new set of
    // results in this cycle, even while an earlier result is still waiting.
    assign s_tready = buf_free;
    assign s_accept = s_tvalid && s_tready;

    // One pass of short logic turns the item and the current state into up to
    // four results and the next state.
    b64c_step u_step (
        .direction  (direction_reg),
        .alphabet   (alphabet_reg),
        .state_cur  (state_reg),
        .data_in    (s_tdata),
        .last_in    (s_tlast),
        .state_next (step_state),
        .res        (step_res),
        .res_count  (step_count)
    );

    always_comb begin
        state_next = state_reg;
        if (cfg_write) begin
            state_next = '0;
        end else if (s_accept) begin
            state_next = step_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
            alphabet_reg  <= ALPH_STD;
            state_reg     <= '0;
        end else begin
            direction_reg <= direction_next;
            alphabet_reg  <= alphabet_next;
            state_reg     <= state_next;
        end
    end

    // The result buffer parts the two sides and hands out one result per
    // transaction on the master side.
    b64c_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_accept),
        .load_res   (step_res),
        .load_count (step_count),
        .can_load   (buf_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (head_res)
    );

    assign m_tdata = head_res.data;
    assign m_tlast = head_res.last;
    assign m_tuser = {head_res.status, head_res.valid};

endmodule

// File: sim/tb_base64_stream_codec_core.sv
`timescale 1ns / 100ps

module tb_base64_stream_codec_core;
    import b64c_pkg::*;

    // Run shape. The cycle limit covers several times the slowest legal run:
    // every item producing four characters, each one waiting out a heavy
    // receiver stall, plus every sender gap.
    localparam int unsigned RANDOM_ITEMS = 370;
    localparam int unsigned MAX_OUT      = 4;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SHOWN_ERRORS = 10;

    // Kinds of rows in the directed table. A typed row carries its single
    // expected result; every other item row is checked against the predictor.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TYPED,
        ROW_SET_DIR,
        ROW_SET_ALPH
    } row_kind_t;

    // Receiver stall patterns; the receiver switches between them at random.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;   // byte or character; register value on a register row
        logic       last;
        b64c_res_t  want;   // only meaningful on a typed row
    } stim_row_t;

    localparam b64c_res_t NO_CHECK = '0;
    localparam int unsigned DIRECTED_ROWS = 31;

    // Directed part. After reset the block encodes with the standard alphabet.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Standard encode: lowest and highest byte values, a four-character
        // group that needs no padding, and a one-byte message padded with "==".
        '{ROW_TYPED,    8'h00, 1'b0, '{"A", 1'b1, 1'b0, STATUS_OK}},
        '{ROW_BYTE,     8'hFF, 1'b0, NO_CHECK},
        '{ROW_BYTE,     8'h80, 1'b1, NO_CHECK},
        '{ROW_BYTE,     8'hFF, 1'b1, NO_CHECK},
        // URL-safe encode: the two symbols that differ, and an unpadded tail.
        '{ROW_SET_ALPH, 8'd1,  1'b0, NO_CHECK},
        '{ROW_TYPED,    8'hFB, 1'b0, '{"-", 1'b1, 1'b0, STATUS_OK}},
        '{ROW_BYTE,     8'hFF, 1'b1, NO_CHECK},
        // URL-safe decode: a length of one symbol is rejected, "-_" decodes
        // and drops its leftover bits, a symbol after padding is an error.
        '{ROW_SET_DIR,  8'd1,  1'b0, NO_CHECK},
        '{ROW_TYPED,    "A",   1'b1, '{8'h00, 1'b0, 1'b1, STATUS_LEN}},
        '{ROW_BYTE,     "-",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "_",   1'b1, NO_CHECK},
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "A",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "A",   1'b1, NO_CHECK},
        // Standard decode: proper double padding, a third pad, padding on a
        // length that is not a multiple of four (length error wins), and a
        // lone invalid character.
        '{ROW_SET_ALPH, 8'd0,  1'b0, NO_CHECK},
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b1, NO_CHECK},
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b1, NO_CHECK},
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_BYTE,     "=",   1'b1, NO_CHECK},
        '{ROW_TYPED,    8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_LEN}},
        // A register write in the middle of a message drops what was gathered.
        '{ROW_BYTE,     "Q",   1'b0, NO_CHECK},
        '{ROW_SET_DIR,  8'd0,  1'b0, NO_CHECK},
        '{ROW_BYTE,     8'h00, 1'b1, NO_CHECK}
    };

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    base64_stream_codec_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Predictor state: the configuration and the per-message codec state.
    logic       decode_mode;
    logic       url_alph;
    logic [5:0] acc_bits;
    logic [2:0] acc_cnt;
    logic [1:0] phase_ctr;
    logic       quad_seen;
    logic [1:0] pad_cnt;
    logic       bad_char;

    b64c_res_t step_results[$];     // results of the item just accepted
    b64c_res_t pending_outputs[$];  // results accepted items still owe

    int unsigned cycle_no = 0;
    int unsigned items_sent = 0;
    int unsigned directed_items = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned len_ends = 0;
    int unsigned char_ends = 0;
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;

    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_hold = 0;
    b64c_res_t   rx_seen;
    b64c_res_t   rx_want;

    function automatic void clear_message();
        acc_bits  = '0;
        acc_cnt   = '0;
        phase_ctr = '0;
        quad_seen = 1'b0;
        pad_cnt   = '0;
        bad_char  = 1'b0;
    endfunction

    function automatic logic [7:0] symbol_for(input logic [5:0] v);
        if (v < 6'd26) return "A" + 8'(v);
        if (v < 6'd52) return "a" + 8'(v - 6'd26);
        if (v < 6'd62) return "0" + 8'(v - 6'd52);
        if (v == 6'd62) return url_alph ? "-" : "+";
        return url_alph ? "_" : "/";
    endfunction

    // Six-bit value of a symbol in the current alphabet, or -1.
    function automatic int symbol_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c - "A");
        if (c >= "a" && c <= "z") return int'(c - "a") + 26;
        if (c >= "0" && c <= "9") return int'(c - "0") + 52;
        if (c == (url_alph ? "-" : "+")) return 62;
        if (c == (url_alph ? "_" : "/")) return 63;
        return -1;
    endfunction

    function automatic void add_result(input logic [7:0] data, input logic valid);
        b64c_res_t r;
        r.data   = data;
        r.valid  = valid;
        r.last   = 1'b0;
        r.status = STATUS_OK;
        step_results.push_back(r);
    endfunction

    // One accepted transaction through the codec: fills step_results and
    // advances the message state.
    function automatic void codec_step(input logic [7:0] d, input logic l);
        logic [13:0]  acc;
        int unsigned  cnt;
        int           idx;
        logic         len_bad;
        b64c_status_t fin;
        b64c_res_t    tail;

        step_results.delete();
        fin = STATUS_OK;
        if (!decode_mode) begin
            acc = {acc_bits, d};
            cnt = acc_cnt + 8;
            while (cnt >= 6) begin
                cnt -= 6;
                add_result(symbol_for(6'(acc >> cnt)), 1'b1);
                phase_ctr++;
            end
            acc_bits = 6'(acc & ((14'd1 << cnt) - 14'd1));
            acc_cnt  = 3'(cnt);
            if (l) begin
                if (acc_cnt != 3'd0) begin
                    add_result(symbol_for(6'(acc_bits << (6 - acc_cnt))), 1'b1);
                    phase_ctr++;
                end
                if (!url_alph) begin
                    while (phase_ctr != 2'd0 && step_results.size() < MAX_OUT) begin
                        add_result("=", 1'b1);
                        phase_ctr++;
                    end
                end
            end
        end else begin
            phase_ctr++;
            if (phase_ctr == 2'd0) quad_seen = 1'b1;
            if (d == "=") begin
                if (pad_cnt >= 2'd2) bad_char = 1'b1;
                else pad_cnt++;
            end else begin
                idx = symbol_value(d);
                if (pad_cnt != 2'd0 || idx < 0) bad_char = 1'b1;
                // Once the message is in error it yields no more bytes.
                if (!bad_char) begin
                    acc = 14'({acc_bits, 6'(idx)});
                    cnt = acc_cnt + 6;
                    if (cnt >= 8) begin
                        cnt -= 8;
                        add_result(8'(acc >> cnt), 1'b1);
                    end
                    acc_bits = 6'(acc & ((14'd1 << cnt) - 14'd1));
                    acc_cnt  = 3'(cnt);
                end
            end
            if (l) begin
                len_bad = url_alph ? (phase_ctr == 2'd1)
                                   : (phase_ctr != 2'd0 || !quad_seen);
                if (pad_cnt != 2'd0 && phase_ctr != 2'd0) bad_char = 1'b1;
                if (len_bad) fin = STATUS_LEN;
                else if (bad_char) fin = STATUS_CHAR;
                // A closing item that decodes to nothing still answers once.
                if (step_results.size() == 0) add_result(8'h00, 1'b0);
            end
        end
        if (l) begin
            tail = step_results.pop_back();
            tail.last   = 1'b1;
            tail.status = fin;
            step_results.push_back(tail);
            clear_message();
        end
    endfunction

    // Sender: bursts of random length, separated by random gaps (often none).
    task automatic send_item(input logic [7:0] d, input logic l,
                             input logic typed, input b64c_res_t want);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
        codec_step(d, l);
        if (typed) pending_outputs.push_back(want);
        else foreach (step_results[k]) pending_outputs.push_back(step_results[k]);
    endtask

    // Let the block go quiet: every owed result delivered, then a settling wait
    // for an item that produced nothing to leave the pipeline.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle held until pready.
    task automatic write_reg(input logic idx, input logic value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_DIRECTION) decode_mode = value;
        else url_alph = value;
        // Any register write abandons the message in progress.
        clear_message();
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random message for the current setting. Decoding mostly uses
    // well-formed text with random content; the rest is noise with stray
    // padding and arbitrary byte values. An open message has no last item.
    task automatic send_random_message(input logic closed);
        logic [7:0]  msg[$];
        int unsigned len;
        int unsigned quads;
        int unsigned tail;
        if (!decode_mode) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 9);
            repeat (len) msg.push_back(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 4) != 0) begin
            quads = $urandom_range(0, 3);
            tail  = $urandom_range(0, 2);  // no tail, two symbols, three symbols
            if (quads == 0 && tail == 0) quads = 1;
            repeat (4 * quads) msg.push_back(symbol_for(6'($urandom_range(0, 63))));
            if (tail != 0) begin
                repeat (tail + 1) msg.push_back(symbol_for(6'($urandom_range(0, 63))));
                // URL-safe text is usually unpadded, but padding is accepted.
                if (!url_alph || $urandom_range(0, 3) == 0)
                    repeat (3 - tail) msg.push_back("=");
            end
        end else begin
            len = $urandom_range(1, 10);
            repeat (len) begin
                case ($urandom_range(0, 3))
                    0, 1:    msg.push_back(symbol_for(6'($urandom_range(0, 63))));
                    2:       msg.push_back("=");
                    default: msg.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        foreach (msg[k]) send_item(msg[k], closed && (k == msg.size() - 1), 1'b0, NO_CHECK);
    endtask

    function automatic void flag_mismatch(input string what, input b64c_res_t want,
                                          input b64c_res_t seen);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("cycle %0d %s: expected data %02h valid %0d last %0d status %0d,",
                     cycle_no, what, want.data, want.valid, want.last, want.status);
            $display("    got data %02h valid %0d last %0d status %0d",
                     seen.data, seen.valid, seen.last, seen.status);
        end
    endfunction

    // Receiver: m_tready follows a stall pattern that changes at random.
    always @(negedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(20, 120);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:  m_tready <= (cycle_no % 7) > 2;
        endcase
    end

    // Result checker: every result transaction is matched against the oldest
    // owed result, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_seen.data   = m_tdata;
            rx_seen.valid  = m_tuser[0];
            rx_seen.last   = m_tlast;
            rx_seen.status = b64c_status_t'(m_tuser[2:1]);
            results_seen++;
            if (rx_seen.last && rx_seen.status == STATUS_LEN) len_ends++;
            if (rx_seen.last && rx_seen.status == STATUS_CHAR) char_ends++;
            if (pending_outputs.size() == 0) begin
                flag_mismatch("result with nothing owed", NO_CHECK, rx_seen);
            end else begin
                rx_want = pending_outputs.pop_front();
                if (rx_seen.data !== rx_want.data || rx_seen.valid !== rx_want.valid ||
                    rx_seen.last !== rx_want.last || rx_seen.status !== rx_want.status)
                    flag_mismatch("result mismatch", rx_want, rx_seen);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("Timed out with %0d results still owed.", pending_outputs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned phase_no;
        logic [1:0]  setting;
        stim_row_t   row;

        decode_mode = 1'b0;
        url_alph    = 1'b0;
        clear_message();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table. Register rows wait for the block to go quiet.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_SET_DIR: begin
                    drain();
                    write_reg(REG_DIRECTION, row.data[0]);
                end
                ROW_SET_ALPH: begin
                    drain();
                    write_reg(REG_ALPHABET, row.data[0]);
                end
                ROW_TYPED: send_item(row.data, row.last, 1'b1, row.want);
                default:   send_item(row.data, row.last, 1'b0, NO_CHECK);
            endcase
        end
        directed_items = items_sent;

        // Random phases. The first four walk every combination of direction
        // and alphabet, later ones pick one at random. Some phases end in the
        // middle of a message, so the next register write has to abort it.
        phase_no = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            setting = (phase_no < 4) ? 2'(phase_no) : 2'($urandom_range(0, 3));
            drain();
            write_reg(REG_DIRECTION, setting[1]);
            write_reg(REG_ALPHABET, setting[0]);
            repeat ($urandom_range(2, 6)) send_random_message(1'b1);
            if ($urandom_range(0, 3) == 0) send_random_message(1'b0);
            phase_no++;
        end
        drain();

        $display("Sent %0d input transactions (%0d directed) over %0d register writes.",
                 items_sent, directed_items, reg_writes);
        $display("Checked %0d results; %0d messages hit a length error, %0d a bad character.",
                 results_seen, len_ends, char_ends);
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/b64c_pkg.sv
rtl/core/b64c_step.sv
rtl/core/b64c_outbuf.sv
rtl/core/base64_stream_codec_core.sv
sim/tb_base64_stream_codec_core.sv
